// ===== design/edge_thinning_nms_defines.svh =====
// Assertion macros used by the asserting top level of the thinning block.
`ifndef EDGE_THINNING_NMS_DEFINES_SVH
`define EDGE_THINNING_NMS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ETN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ETN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/etn_pkg.sv =====
package etn_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 11;
  localparam int DIM_W       = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int MIN_DIM     = 3;

  localparam logic [DIM_W-1:0] RESET_WIDTH     = 12'd800;
  localparam logic [DIM_W-1:0] RESET_HEIGHT    = 12'd600;
  localparam logic             RESET_THR_EN    = 1'b1;
  localparam logic [PIX_W-1:0] RESET_THRESHOLD = 8'd48;
  localparam logic [PIX_W-1:0] RESET_MARK      = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH      = 3'd0,
    CFG_IMAGE_HEIGHT     = 3'd1,
    CFG_THRESHOLD_ENABLE = 3'd2,
    CFG_THRESHOLD        = 3'd3,
    CFG_MARK_VALUE       = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [PIX_W-1:0]   value;
    logic               last;
  } res_item_t;

  // Threshold settings handed from the register file to the window.
  typedef struct packed {
    logic             enable;
    logic [PIX_W-1:0] level;
    logic [PIX_W-1:0] mark;
  } thr_cfg_t;

  // One new window column: two line-store taps and the incoming pixel.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Per-item position information carried alongside the pipeline.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
  } meta_t;

  // Limits a requested frame dimension to the range the hardware supports.
  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r < MIN_DIM) begin
      r = MIN_DIM;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ===== design/etn_cfg_regs.sv =====
module etn_cfg_regs #(
  parameter int MAX_WIDTH  = etn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = etn_pkg::DEF_MAX_HEIGHT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [etn_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [etn_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [WW-1:0]                     width,
  output logic [HW-1:0]                     height,
  output etn_pkg::thr_cfg_t                 thr
);

  // Dimensions are stored already clamped, so the datapath never sees
  // an out-of-range size.
  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= WW'(etn_pkg::clamp_dim(etn_pkg::RESET_WIDTH, MAX_WIDTH));
      height     <= HW'(etn_pkg::clamp_dim(etn_pkg::RESET_HEIGHT, MAX_HEIGHT));
      thr.enable <= etn_pkg::RESET_THR_EN;
      thr.level  <= etn_pkg::RESET_THRESHOLD;
      thr.mark   <= etn_pkg::RESET_MARK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        etn_pkg::CFG_IMAGE_WIDTH: begin
          width <= WW'(etn_pkg::clamp_dim(cfg_data[etn_pkg::DIM_W-1:0], MAX_WIDTH));
        end
        etn_pkg::CFG_IMAGE_HEIGHT: begin
          height <= HW'(etn_pkg::clamp_dim(cfg_data[etn_pkg::DIM_W-1:0], MAX_HEIGHT));
        end
        etn_pkg::CFG_THRESHOLD_ENABLE: begin
          thr.enable <= cfg_data[0];
        end
        etn_pkg::CFG_THRESHOLD: begin
          thr.level <= cfg_data[etn_pkg::PIX_W-1:0];
        end
        etn_pkg::CFG_MARK_VALUE: begin
          thr.mark <= cfg_data[etn_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/etn_line_store.sv =====
module etn_line_store #(
  parameter int MAX_WIDTH = etn_pkg::DEF_MAX_WIDTH,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int EW = 2 * etn_pkg::PIX_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [XW-1:0]             rd_addr,
  input  logic                      rd_bank,
  input  logic [etn_pkg::PIX_W-1:0] rd_pix,
  input  logic                      wr_en,
  output etn_pkg::col_t             col
);

  // Each entry holds both line banks of one column: even rows in the low
  // byte, odd rows in the high byte.
  logic [EW-1:0]             mem [MAX_WIDTH];
  logic [EW-1:0]             rdata;
  logic [EW-1:0]             fwd_data;
  logic                      fwd_hit;
  logic [XW-1:0]             s1_addr;
  logic                      s1_bank;
  logic [etn_pkg::PIX_W-1:0] s1_pix;
  logic [EW-1:0]             cur;
  logic [EW-1:0]             wdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // A read of the column being written back in the same cycle takes the
  // new entry instead of the stale memory word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr  <= rd_addr;
      s1_bank  <= rd_bank;
      s1_pix   <= rd_pix;
      fwd_data <= wdata;
    end
  end

  always_comb begin
    cur = fwd_hit ? fwd_data : rdata;
    if (s1_bank) begin
      col.top = cur[EW-1:etn_pkg::PIX_W];
      col.mid = cur[etn_pkg::PIX_W-1:0];
      wdata   = {s1_pix, cur[etn_pkg::PIX_W-1:0]};
    end else begin
      col.top = cur[etn_pkg::PIX_W-1:0];
      col.mid = cur[EW-1:etn_pkg::PIX_W];
      wdata   = {cur[EW-1:etn_pkg::PIX_W], s1_pix};
    end
    col.bot = s1_pix;
  end

endmodule

// ===== design/etn_nms_window.sv =====
module etn_nms_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  etn_pkg::col_t             col,
  input  etn_pkg::thr_cfg_t         thr,
  output logic [etn_pkg::PIX_W-1:0] value
);

  logic [etn_pkg::PIX_W-1:0] win [3][3];
  logic [etn_pkg::PIX_W-1:0] ctr;
  logic [etn_pkg::PIX_W-1:0] kept;
  logic                      is_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= col.top;
      win[1][2] <= col.mid;
      win[2][2] <= col.bot;
    end
  end

  // The center survives when it is a strict maximum along any of the
  // horizontal, two diagonal or vertical directions.
  always_comb begin
    ctr     = win[1][1];
    is_peak = (win[1][0] < ctr && win[1][2] < ctr) ||
              (win[2][0] < ctr && win[0][2] < ctr) ||
              (win[0][1] < ctr && win[2][1] < ctr) ||
              (win[0][0] < ctr && win[2][2] < ctr);
    kept    = is_peak ? ctr : '0;
    if (thr.enable) begin
      value = (kept >= thr.level) ? thr.mark : '0;
    end else begin
      value = kept;
    end
  end

endmodule

// ===== design/edge_thinning_nms.sv =====
// Streaming 3x3 non-maximum suppression over 8-bit edge-magnitude pixels in
// raster order, with an optional single threshold on the surviving values.
// The block takes one pixel per clock. Each accepted pixel completes the
// neighborhood of the pixel one row up and one column left; when that pixel
// is interior, one result item follows via stages one and two and the
// output register, else none. The pixel rate is set by the line store, a
// single memory with one read and one write port that is read at acceptance
// and written back from stage one, so every column costs exactly one
// read-modify-write. A back-to-back repeat of a column (a frame start right
// after column zero) is covered by forwarding the written-back entry. The
// line store needs no clearing pass after reset. Results leave through an
// output register backed by one skid entry, so input is held back only when
// both hold results. Configuration is written through cfg_write, cfg_index
// and cfg_data while the block is idle, a rule on the user that the block
// does not enforce. Widths and heights outside 3 to the maximum are clamped.
`include "edge_thinning_nms_defines.svh"

module edge_thinning_nms #(
  parameter int MAX_WIDTH  = etn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = etn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  etn_pkg::pix_item_t              pix_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output etn_pkg::res_item_t              res_item,
  input  logic                            cfg_write,
  input  logic [etn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [etn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]             width;
  logic [HW-1:0]             height;
  etn_pkg::thr_cfg_t         thr;

  // Position of the next pixel.
  logic [XW-1:0]             column_count;
  logic [YW-1:0]             row_count;
  logic [XW-1:0]             column_count_next;
  logic [YW-1:0]             row_count_next;
  logic [XW-1:0]             x_cur;
  logic [YW-1:0]             y_cur;
  logic [WW-1:0]             x_inc;
  logic [HW-1:0]             y_inc;
  logic [WW-1:0]             x_less;

  logic                      accept;
  logic                      adv;
  logic                      push;
  etn_pkg::meta_t            meta_in;
  logic                      s1_valid;
  etn_pkg::meta_t            s1_meta;
  logic                      s2_valid;
  etn_pkg::meta_t            s2_meta;
  etn_pkg::col_t             col;
  logic [etn_pkg::PIX_W-1:0] value;
  etn_pkg::res_item_t        result;
  logic                      skid_valid;
  etn_pkg::res_item_t        skid_item;

  // The whole pipeline moves together; it only stops once the skid entry
  // is occupied, which means the output register is full as well.
  assign adv       = !skid_valid;
  assign pix_ready = adv;
  assign accept    = pix_valid && pix_ready;
  assign push      = adv && s2_valid && s2_meta.emit;

  etn_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .width    (width),
    .height   (height),
    .thr      (thr)
  );

  // A frame start places the pixel at the origin before anything else.
  // After the last column the row advances, and after the last row the
  // position wraps to the origin. A row count left beyond a smaller new
  // height wraps at the next pixel even within the line.
  always_comb begin
    x_cur  = pix_item.frame_start ? '0 : column_count;
    y_cur  = pix_item.frame_start ? '0 : row_count;
    x_inc  = WW'(x_cur) + WW'(1);
    y_inc  = HW'(y_cur) + HW'(1);
    x_less = WW'(x_cur) - WW'(1);
    if (x_inc >= width) begin
      column_count_next = '0;
      row_count_next    = (y_inc >= height) ? '0 : YW'(y_inc);
    end else begin
      column_count_next = XW'(x_inc);
      row_count_next    = (HW'(y_cur) >= height) ? '0 : y_cur;
    end
    meta_in.emit   = (x_cur >= XW'(2)) && (y_cur >= YW'(2)) &&
                     (WW'(x_cur) < width) && (HW'(y_cur) < height);
    meta_in.last   = (WW'(x_cur) == width - WW'(1)) &&
                     (HW'(y_cur) == height - HW'(1));
    meta_in.column = etn_pkg::COORD_W'(x_less);
    meta_in.line   = etn_pkg::COORD_W'(HW'(y_cur) - HW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage one waits for the line-store read; stage two holds the item
  // whose neighborhood now sits in the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta <= meta_in;
      s2_meta <= s1_meta;
    end
  end

  // Line parity selects the bank that is replaced; the other bank holds
  // the line in between.
  etn_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_lines (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(x_cur),
    .rd_bank(y_cur[0]),
    .rd_pix (pix_item.pixel),
    .wr_en  (adv && s1_valid),
    .col    (col)
  );

  etn_nms_window u_window (
    .clk  (clk),
    .rst  (rst),
    .shift(adv && s1_valid),
    .col  (col),
    .thr  (thr),
    .value(value)
  );

  always_comb begin
    result.column = s2_meta.column;
    result.line   = s2_meta.line;
    result.value  = value;
    result.last   = s2_meta.last;
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_item <= skid_item;
      end else if (push) begin
        res_item <= result;
      end
    end else if (push) begin
      skid_item <= result;
    end
  end

  `ETN_ASSERT_NOW(a_skid_behind_head, clk, rst, skid_valid, res_valid,
    "skid entry occupied while the output register is empty")
  `ETN_ASSERT_NEXT(a_result_kept, clk, rst, res_valid && !res_ready && push, skid_valid,
    "result pushed into a stalled output was not kept in the skid entry")
  `ETN_ASSERT_NEXT(a_frame_origin, clk, rst, accept && pix_item.frame_start,
    column_count == XW'(1) && row_count == '0,
    "position after a frame start is not column one of row zero")

endmodule
